/* rtl/mtg_pkg.sv */
package mtg_pkg;

  localparam int unsigned MT_WORDS     = 624;
  localparam int unsigned MT_SHIFT     = 397;
  localparam int unsigned IDX_W        = $clog2(MT_WORDS);
  localparam int unsigned TOK_DEPTH    = 4;
  localparam int unsigned TOK_CNT_W    = $clog2(TOK_DEPTH + 1);

  localparam logic [31:0] MT_UPPER       = 32'h8000_0000;
  localparam logic [31:0] MT_LOWER       = 32'h7FFF_FFFF;
  localparam logic [31:0] MT_MATRIX      = 32'h9908_B0DF;
  localparam logic [31:0] MT_TEMPER_B    = 32'h9D2C_5680;
  localparam logic [31:0] MT_TEMPER_C    = 32'hEFC6_0000;
  localparam logic [31:0] MT_INIT_MULT   = 32'd1812433253;
  localparam logic [31:0] MT_DEFAULT_SEED = 32'd5489;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MT_WORDS - 1);
  localparam logic [IDX_W:0]   WORDS_EXT = (IDX_W + 1)'(MT_WORDS);

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [TOK_CNT_W-1:0] tok_cnt_t;

  // state-array write request from the seeding sequencer
  typedef struct packed {
    logic        busy;
    logic        we;
    idx_t        addr;
    logic [31:0] data;
  } fill_t;

  // circular index add; base + off always stays below twice the array size
  function automatic idx_t wrap_add(input idx_t base, input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= WORDS_EXT) begin
      sum = sum - WORDS_EXT;
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] x_in);
    logic [31:0] x;
    x = x_in;
    x = x ^ (x >> 11);
    x = x ^ ((x << 7) & MT_TEMPER_B);
    x = x ^ ((x << 15) & MT_TEMPER_C);
    x = x ^ (x >> 18);
    return x;
  endfunction

endpackage

/* rtl/mtg_front.sv */
module mtg_front import mtg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [0] draw
  input  logic       tok_pop,
  output logic       tok_avail
);

  tok_cnt_t cnt_r, cnt_nxt;
  logic     push;

  assign in_tready = (cnt_r != tok_cnt_t'(TOK_DEPTH));
  // a word with draw clear is taken and dropped
  assign push      = in_tvalid && in_tready && in_tdata[0];
  assign tok_avail = (cnt_r != '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !tok_pop) begin
      cnt_nxt = cnt_r + tok_cnt_t'(1);
    end else if (!push && tok_pop) begin
      cnt_nxt = cnt_r - tok_cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/mtg_seed.sv */
module mtg_seed import mtg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [31:0] cfg_tdata,   // [31:0] seed_value
  output fill_t       fill
);

  logic [31:0] seed_r;
  logic [31:0] prev_r;
  idx_t        cnt_r;
  logic        busy_r;
  logic [31:0] mixed;
  logic [31:0] prod;
  logic [31:0] wdata;

  assign cfg_tready = 1'b1;

  assign mixed = prev_r ^ (prev_r >> 30);
  assign prod  = MT_INIT_MULT * mixed;
  assign wdata = (cnt_r == '0) ? seed_r : prod + {{(32-IDX_W){1'b0}}, cnt_r};

  assign fill.busy = busy_r;
  assign fill.we   = busy_r;
  assign fill.addr = cnt_r;
  assign fill.data = wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= MT_DEFAULT_SEED;
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (cfg_tvalid) begin
      seed_r <= cfg_tdata;
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r == LAST_IDX) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r + idx_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      prev_r <= wdata;
    end
  end

endmodule

/* rtl/mtg_back.sv */
module mtg_back import mtg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  fill_t       fill,
  input  logic        tok_avail,
  output logic        tok_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] random_word
);

  logic [31:0] mem [MT_WORDS];
  logic [31:0] rd_next_r;
  logic [31:0] rd_far_r;
  logic [31:0] cur_r;
  idx_t        pos_r, pos_nxt;
  logic        out_valid_r;
  logic [31:0] out_data_r;

  logic        fire;
  idx_t        ra_next;
  idx_t        ra_far;
  logic [31:0] y;
  logic [31:0] twisted;
  logic [31:0] w;
  logic        we;
  idx_t        wa;
  logic [31:0] wd;

  assign fire    = tok_avail && !fill.busy && (!out_valid_r || out_tready);
  assign tok_pop = fire;

  // rd_next_r/rd_far_r always hold words pos+1 and pos+397 for the coming cycle
  assign pos_nxt = fill.busy ? '0 : (fire ? wrap_add(pos_r, idx_t'(1)) : pos_r);
  assign ra_next = wrap_add(pos_nxt, idx_t'(1));
  assign ra_far  = wrap_add(pos_nxt, idx_t'(MT_SHIFT));

  assign y       = (cur_r & MT_UPPER) | (rd_next_r & MT_LOWER);
  assign twisted = (y >> 1) ^ (rd_next_r[0] ? MT_MATRIX : 32'd0);
  assign w       = rd_far_r ^ twisted;

  assign we = fill.we || fire;
  assign wa = fill.we ? fill.addr : pos_r;
  assign wd = fill.we ? fill.data : w;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_next_r <= mem[ra_next];
    rd_far_r  <= mem[ra_far];
  end

  always_ff @(posedge clk) begin
    if (fill.we && fill.addr == '0) begin
      cur_r <= fill.data;
    end else if (fire) begin
      cur_r <= rd_next_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= temper(w);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* rtl/mersenne_twister_generator_unit.sv */
// a draw word is counted as a token, then its result is registered when the token fires
// throughput: one word per cycle without refill or stall, set by the single write port
// draws with the draw bit clear are accepted and produce no word
// reset (rst_n low, synchronous) loads seed 5489, then fills the 624-word state memory
// a seed write refills the state memory; up to 4 draws are taken and held meanwhile
module mersenne_twister_generator_unit import mtg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [0] draw
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [31:0] random_word
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [31:0] cfg_tdata    // [31:0] seed_value
);

  fill_t fill;
  logic  tok_pop;
  logic  tok_avail;

  mtg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .tok_pop   (tok_pop),
    .tok_avail (tok_avail)
  );

  mtg_seed u_seed (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata),
    .fill       (fill)
  );

  mtg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fill       (fill),
    .tok_avail  (tok_avail),
    .tok_pop    (tok_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
